/* hdl/prng_pkg.sv */
// ----------------------------------------------------------------------------
// prng_pkg
// Shared types and constants for the bounded-range pseudo-random generator.
// ----------------------------------------------------------------------------
package prng_pkg;

   localparam int unsigned StateWidth = 64;
   localparam int unsigned HalfWidth  = 32;
   localparam int unsigned OpWidth    = 2;
   localparam int unsigned TryBits    = 16;

   localparam logic [HalfWidth-1:0]  LcgMul   = 32'd1664525;
   localparam logic [StateWidth-1:0] LcgInc   = 64'd84971284;
   localparam logic [StateWidth-1:0] MixMul   = 64'hbf58476d1ce4e5b9;
   localparam int unsigned           PreShl   = 9;
   localparam int unsigned           PreShr   = 30;
   localparam int unsigned           PreFold  = 37;
   localparam int unsigned           PostFold = 19;

   typedef enum logic [OpWidth-1:0] {
      OP_RESEED = 2'd0,
      OP_RAW    = 2'd1,
      OP_RANGED = 2'd2
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LCG_LO,
      ST_LCG_HI,
      ST_LCG_ADD,
      ST_MIX0,
      ST_MIX1,
      ST_MIX2,
      ST_MIX3,
      ST_LIMIT,
      ST_CHECK,
      ST_MOD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                  start;
      logic                  half;
      logic [StateWidth-1:0] dividend;
      logic [HalfWidth-1:0]  divisor;
   } rem_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [HalfWidth-1:0] remainder;
   } rem_sts_type;

   function automatic logic [StateWidth-1:0] premix(input logic [StateWidth-1:0] v);
      logic [StateWidth-1:0] p;
      p = (v << PreShl) ^ (v >> PreShr);
      p = p ^ (p >> PreFold);
      return p;
   endfunction

endpackage

/* hdl/prng_if.sv */
// ----------------------------------------------------------------------------
// prng_if
// Valid/ready channels for draw requests and draw responses.
// ----------------------------------------------------------------------------
interface prng_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [prng_pkg::OpWidth-1:0]           opcode;
   logic [prng_pkg::StateWidth-1:0]        seed_value;
   logic signed [prng_pkg::HalfWidth-1:0]  range_min;
   logic signed [prng_pkg::HalfWidth-1:0]  range_max;

   modport source (output valid, opcode, seed_value, range_min, range_max, input ready);
   modport sink   (input valid, opcode, seed_value, range_min, range_max, output ready);
endinterface

interface prng_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [prng_pkg::StateWidth-1:0] value;

   modport source (output valid, value, input ready);
   modport sink   (input valid, value, output ready);
endinterface

/* hdl/prng_rem.sv */
// ----------------------------------------------------------------------------
// prng_rem
// Bit-serial restoring remainder unit: 64- or 32-bit dividend, 32-bit divisor.
// ----------------------------------------------------------------------------
module prng_rem (
   input  logic                  clock,
   input  logic                  reset,
   input  prng_pkg::rem_cmd_type cmd,
   output prng_pkg::rem_sts_type sts
);

   localparam int unsigned DvdWidth = prng_pkg::StateWidth;
   localparam int unsigned DivWidth = prng_pkg::HalfWidth;
   localparam int unsigned CntWidth = $clog2(DvdWidth + 1);
   localparam logic [CntWidth-1:0] FullCount = CntWidth'(DvdWidth);
   localparam logic [CntWidth-1:0] HalfCount = CntWidth'(DivWidth);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [DvdWidth-1:0] dvd_ff;
   logic [DivWidth-1:0] div_ff;
   logic [DivWidth-1:0] rem_ff, rem_in;

   logic [DivWidth:0]   trial;
   logic [DivWidth+1:0] diff;

   assign trial = {rem_ff, dvd_ff[DvdWidth-1]};
   assign diff  = {1'b0, trial} - {2'b00, div_ff};
   assign rem_in = diff[DivWidth+1] ? trial[DivWidth-1:0] : diff[DivWidth-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.half ? HalfCount : FullCount;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CntWidth'(1);
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dvd_ff <= cmd.dividend;
         div_ff <= cmd.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= rem_in;
      end
   end

   assign sts.done      = done_ff;
   assign sts.remainder = rem_ff;

endmodule

/* hdl/prng_with_bounded_range_draw.sv */
// ----------------------------------------------------------------------------
// prng_with_bounded_range_draw
// 64-bit LCG with multiply/xor-shift output mixer and rejection-sampled ranged draws.
// ----------------------------------------------------------------------------
// One request transaction is handled at a time; req_if.ready is high only when
// idle. A reseed gives no response. A raw draw steps the LCG and then mixes the
// output: the LCG step and the output mix share one registered 32x32
// multiplier, five partial products in sequence. A ranged draw first runs the
// bit-serial remainder unit over 64 bits for the rejection limit, then one LCG
// step and output mix per draw attempt, at most 65536 attempts, then 32
// bit-steps for x mod range. A full-range draw skips both remainder passes.
// The response is held in a register until taken.
// ----------------------------------------------------------------------------
module prng_with_bounded_range_draw (
   input logic          clock,
   input logic          reset,
   prng_req_if.sink     req_if,
   prng_rsp_if.source   rsp_if
);

   localparam int unsigned SW = prng_pkg::StateWidth;
   localparam int unsigned HW = prng_pkg::HalfWidth;
   localparam int unsigned TB = prng_pkg::TryBits;

   prng_pkg::state_type   state_ff, state_in;
   logic [SW-1:0]         gen_ff;
   logic [SW-1:0]         mix_ff;
   logic [SW-1:0]         acc_ff;
   logic [SW-1:0]         prod_ff, prod_in;
   logic [SW-1:0]         draw_ff;
   logic [SW-1:0]         value_ff;
   logic [prng_pkg::OpWidth-1:0] op_ff;
   logic [HW-1:0]         range_ff;
   logic [HW-1:0]         lo_ff;
   logic [HW-1:0]         limit_ff;
   logic [TB-1:0]         tries_ff;

   logic [HW-1:0]         mul_a, mul_b;
   logic [HW-1:0]         range_in;
   logic [SW-1:0]         lcg_sum, mix_sum, mix_fin;
   logic                  accept, retry;

   prng_pkg::rem_cmd_type rem_cmd;
   prng_pkg::rem_sts_type rem_sts;

   prng_rem u_rem (
      .clock (clock),
      .reset (reset),
      .cmd   (rem_cmd),
      .sts   (rem_sts)
   );

   assign accept   = req_if.valid && req_if.ready;
   assign range_in = $unsigned(req_if.range_max) - $unsigned(req_if.range_min) + HW'(1);
   assign retry    = (draw_ff[HW-1:0] >= limit_ff) && (tries_ff != '1);
   assign lcg_sum  = acc_ff + {prod_ff[HW-1:0], {HW{1'b0}}};
   assign mix_sum  = acc_ff + {prod_ff[HW-1:0], {HW{1'b0}}};
   assign mix_fin  = mix_sum ^ (mix_sum >> prng_pkg::PostFold);
   assign prod_in  = {{HW{1'b0}}, mul_a} * {{HW{1'b0}}, mul_b};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prng_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_if.opcode)
                  prng_pkg::OP_RAW:    state_in = prng_pkg::ST_LCG_LO;
                  prng_pkg::OP_RANGED: state_in = (range_in == '0) ? prng_pkg::ST_LCG_LO
                                                                   : prng_pkg::ST_LIMIT;
                  default:             state_in = prng_pkg::ST_IDLE;
               endcase
            end
         end
         prng_pkg::ST_LCG_LO:  state_in = prng_pkg::ST_LCG_HI;
         prng_pkg::ST_LCG_HI:  state_in = prng_pkg::ST_LCG_ADD;
         prng_pkg::ST_LCG_ADD: state_in = prng_pkg::ST_MIX0;
         prng_pkg::ST_MIX0:    state_in = prng_pkg::ST_MIX1;
         prng_pkg::ST_MIX1:    state_in = prng_pkg::ST_MIX2;
         prng_pkg::ST_MIX2:    state_in = prng_pkg::ST_MIX3;
         prng_pkg::ST_MIX3: begin
            state_in = (op_ff == prng_pkg::OP_RAW) ? prng_pkg::ST_RESP : prng_pkg::ST_CHECK;
         end
         prng_pkg::ST_LIMIT: begin
            if (rem_sts.done) state_in = prng_pkg::ST_LCG_LO;
         end
         prng_pkg::ST_CHECK: begin
            if (range_ff == '0)  state_in = prng_pkg::ST_RESP;
            else if (retry)      state_in = prng_pkg::ST_LCG_LO;
            else                 state_in = prng_pkg::ST_MOD;
         end
         prng_pkg::ST_MOD: begin
            if (rem_sts.done) state_in = prng_pkg::ST_RESP;
         end
         prng_pkg::ST_RESP: begin
            if (rsp_if.ready) state_in = prng_pkg::ST_IDLE;
         end
         default: state_in = prng_pkg::ST_IDLE;
      endcase
   end

   // outputs and shared-unit control
   always_comb begin
      req_if.ready     = 1'b0;
      rsp_if.valid     = 1'b0;
      mul_a            = gen_ff[HW-1:0];
      mul_b            = prng_pkg::LcgMul;
      rem_cmd.start    = 1'b0;
      rem_cmd.half     = 1'b0;
      rem_cmd.dividend = '1;
      rem_cmd.divisor  = range_in;
      unique case (state_ff)
         prng_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid && req_if.opcode == prng_pkg::OP_RANGED && range_in != '0) begin
               rem_cmd.start = 1'b1;
            end
         end
         prng_pkg::ST_LCG_HI: mul_a = gen_ff[SW-1:HW];
         prng_pkg::ST_MIX0: begin
            mul_a = mix_ff[HW-1:0];
            mul_b = prng_pkg::MixMul[HW-1:0];
         end
         prng_pkg::ST_MIX1: begin
            mul_a = mix_ff[HW-1:0];
            mul_b = prng_pkg::MixMul[SW-1:HW];
         end
         prng_pkg::ST_MIX2: begin
            mul_a = mix_ff[SW-1:HW];
            mul_b = prng_pkg::MixMul[HW-1:0];
         end
         prng_pkg::ST_CHECK: begin
            rem_cmd.half     = 1'b1;
            rem_cmd.dividend = {draw_ff[HW-1:0], {HW{1'b0}}};
            rem_cmd.divisor  = range_ff;
            rem_cmd.start    = (range_ff != '0) && !retry;
         end
         prng_pkg::ST_RESP: rsp_if.valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prng_pkg::ST_IDLE;
         gen_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (accept && req_if.opcode == prng_pkg::OP_RESEED) begin
            gen_ff <= req_if.seed_value;
         end else if (state_ff == prng_pkg::ST_LCG_ADD) begin
            gen_ff <= lcg_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (accept) begin
         op_ff    <= req_if.opcode;
         range_ff <= range_in;
         lo_ff    <= $unsigned(req_if.range_min);
         tries_ff <= '0;
      end
      case (state_ff)
         prng_pkg::ST_LCG_HI:  acc_ff <= prod_ff + prng_pkg::LcgInc;
         prng_pkg::ST_LCG_ADD: mix_ff <= prng_pkg::premix(lcg_sum);
         prng_pkg::ST_MIX1:    acc_ff <= prod_ff;
         prng_pkg::ST_MIX2:    acc_ff <= mix_sum;
         prng_pkg::ST_MIX3: begin
            draw_ff <= mix_fin;
            if (op_ff == prng_pkg::OP_RAW) value_ff <= mix_fin;
         end
         prng_pkg::ST_LIMIT: begin
            if (rem_sts.done) limit_ff <= '1 - rem_sts.remainder;
         end
         prng_pkg::ST_CHECK: begin
            if (range_ff == '0) begin
               value_ff <= {{HW{1'b0}}, lo_ff + draw_ff[HW-1:0]};
            end else if (retry) begin
               tries_ff <= tries_ff + TB'(1);
            end
         end
         prng_pkg::ST_MOD: begin
            if (rem_sts.done) value_ff <= {{HW{1'b0}}, lo_ff + rem_sts.remainder};
         end
         default: ;
      endcase
   end

   assign rsp_if.value = value_ff;

`ifndef SYNTH
   a_rem_done_expected: assert property (@(posedge clock) disable iff (reset)
      rem_sts.done |-> (state_ff == prng_pkg::ST_LIMIT || state_ff == prng_pkg::ST_MOD))
      else $error("remainder completion outside a remainder wait");

   a_busy_after_draw_req: assert property (@(posedge clock) disable iff (reset)
      accept && (req_if.opcode == prng_pkg::OP_RAW || req_if.opcode == prng_pkg::OP_RANGED)
      |=> !req_if.ready)
      else $error("request taken while a draw is in progress");

   a_try_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == prng_pkg::ST_CHECK && tries_ff == '1 |=> state_ff != prng_pkg::ST_LCG_LO)
      else $error("ranged draw retried beyond the attempt cap");

   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready |=> state_ff == prng_pkg::ST_IDLE && !rsp_if.valid)
      else $error("response not retired after transaction");
`endif

endmodule

/* test/prng_with_bounded_range_draw_tb.sv */
// ----------------------------------------------------------------------------
// prng_with_bounded_range_draw_tb
// Self-checking bench for the generator: reseed, raw, ranged and unused-opcode
// requests are driven with random gaps, responses are taken with random
// back-pressure and each one is compared against values worked out by a
// behavioural copy of the generator state kept inside the bench.
// ----------------------------------------------------------------------------
module prng_with_bounded_range_draw_tb;

   localparam logic [prng_pkg::OpWidth-1:0]    OP_UNUSED    = 2'd3;
   localparam logic [prng_pkg::StateWidth-1:0] STEP_MUL     = 64'd1664525;
   localparam logic [prng_pkg::StateWidth-1:0] STEP_INC     = 64'd84971284;
   localparam logic [prng_pkg::StateWidth-1:0] SCRAMBLE_MUL = 64'hbf58476d1ce4e5b9;
   localparam int unsigned           MAX_ATTEMPTS = 65536;
   localparam int unsigned           RANDOM_DRAWS = 1950;
   localparam int unsigned           IDLE_PCT     = 18;
   localparam int unsigned           DRAIN_CYCLES = 300;
   localparam longint unsigned       CYCLE_LIMIT  = 3_000_000;
   localparam longint unsigned       CALM_FROM    = 60_000;
   localparam longint unsigned       CALM_TO      = 100_000;

   typedef struct packed {
      logic [prng_pkg::OpWidth-1:0]    opcode;
      logic [prng_pkg::StateWidth-1:0] seed;
      logic [prng_pkg::HalfWidth-1:0]  lo;
      logic [prng_pkg::HalfWidth-1:0]  hi;
   } draw_req_type;

   logic clock;
   logic reset;

   prng_req_if req_chan ();
   prng_rsp_if rsp_chan ();

   prng_with_bounded_range_draw dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   draw_req_type                    pending[$];
   logic [prng_pkg::StateWidth-1:0] expected_values[$];
   logic [prng_pkg::StateWidth-1:0] gen_state;
   longint unsigned                 cycle_count;
   int unsigned                     mismatches;
   logic                            calm;

   assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [prng_pkg::StateWidth-1:0] next_draw();
      logic [prng_pkg::StateWidth-1:0] s;
      gen_state = gen_state * STEP_MUL + STEP_INC;
      s = (gen_state << 9) ^ (gen_state >> 30);
      s = s ^ (s >> 37);
      s = s * SCRAMBLE_MUL;
      s = s ^ (s >> 19);
      return s;
   endfunction

   function automatic logic [prng_pkg::HalfWidth-1:0] bounded_draw(
      input logic [prng_pkg::HalfWidth-1:0] lo,
      input logic [prng_pkg::HalfWidth-1:0] hi);
      logic [prng_pkg::HalfWidth-1:0]  span;
      logic [prng_pkg::StateWidth-1:0] rem;
      logic [prng_pkg::HalfWidth-1:0]  limit;
      logic [prng_pkg::StateWidth-1:0] d;
      logic [prng_pkg::HalfWidth-1:0]  x;
      int unsigned                     attempts;
      span = hi - lo + 32'd1;
      if (span == '0) begin
         d = next_draw();
         return lo + d[prng_pkg::HalfWidth-1:0];
      end
      rem      = 64'hFFFF_FFFF_FFFF_FFFF % {32'd0, span};
      limit    = 32'hFFFF_FFFF - rem[prng_pkg::HalfWidth-1:0];
      attempts = 0;
      do begin
         d = next_draw();
         x = d[prng_pkg::HalfWidth-1:0];
         attempts++;
      end while (x >= limit && attempts < MAX_ATTEMPTS);
      return lo + (x % span);
   endfunction

   task automatic predict_transaction(input draw_req_type r);
      case (r.opcode)
         prng_pkg::OP_RESEED: gen_state = r.seed;
         prng_pkg::OP_RAW:    expected_values.push_back(next_draw());
         prng_pkg::OP_RANGED: expected_values.push_back({32'd0, bounded_draw(r.lo, r.hi)});
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic queue_request(input logic [prng_pkg::OpWidth-1:0]    op,
                                input logic [prng_pkg::StateWidth-1:0] seed,
                                input logic [prng_pkg::HalfWidth-1:0]  lo,
                                input logic [prng_pkg::HalfWidth-1:0]  hi);
      draw_req_type r;
      r.opcode = op;
      r.seed   = seed;
      r.lo     = lo;
      r.hi     = hi;
      pending.push_back(r);
   endtask

   always @(posedge clock) begin : request_driver
      draw_req_type item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            item = pending.pop_front();
            req_chan.valid      <= 1'b1;
            req_chan.opcode     <= item.opcode;
            req_chan.seed_value <= item.seed;
            req_chan.range_min  <= item.lo;
            req_chan.range_max  <= item.hi;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      logic [prng_pkg::StateWidth-1:0] want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         gen_state = '0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_transaction({req_chan.opcode, req_chan.seed_value,
                                 req_chan.range_min, req_chan.range_max});
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_values.size() == 0) begin
               report_mismatch($sformatf("unexpected value %h", rsp_chan.value));
            end else begin
               want = expected_values.pop_front();
               if (rsp_chan.value !== want)
                  report_mismatch($sformatf("value expected %h actual %h",
                                            want, rsp_chan.value));
            end
         end
         rsp_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("prng_with_bounded_range_draw regression: fail");
         $finish;
      end
   end

   initial begin
      draw_req_type item;
      int unsigned  drawn;
      int unsigned  pick;
      clock               = 1'b0;
      reset               = 1'b1;
      cycle_count         = 0;
      mismatches          = 0;
      req_chan.valid      = 1'b0;
      req_chan.opcode     = prng_pkg::OP_RESEED;
      req_chan.seed_value = '0;
      req_chan.range_min  = '0;
      req_chan.range_max  = '0;
      rsp_chan.ready      = 1'b0;

      // from the reset state, then extreme seeds
      queue_request(prng_pkg::OP_RAW,    '0, '0, '0);
      queue_request(prng_pkg::OP_RANGED, '0, 32'd0, 32'd9);
      queue_request(prng_pkg::OP_RESEED, '0, '0, '0);
      queue_request(prng_pkg::OP_RAW,    '0, '0, '0);
      queue_request(prng_pkg::OP_RESEED, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
      queue_request(prng_pkg::OP_RAW,    '0, '0, '0);
      queue_request(prng_pkg::OP_RESEED, 64'h8000_0000_0000_0000, '0, '0);
      queue_request(prng_pkg::OP_RAW,    '0, '0, '0);
      // single-value, full, near-full and inverted bounds
      queue_request(prng_pkg::OP_RANGED, '0, 32'd0, 32'd0);
      queue_request(prng_pkg::OP_RANGED, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_request(prng_pkg::OP_RANGED, '0, 32'h8000_0000, 32'h8000_0000);
      queue_request(prng_pkg::OP_RANGED, '0, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_request(prng_pkg::OP_RANGED, '0, 32'h8000_0000, 32'h7FFF_FFFE);
      queue_request(prng_pkg::OP_RANGED, '0, 32'd1, 32'd0);
      queue_request(prng_pkg::OP_RANGED, '0, 32'd100, -32'sd100);
      queue_request(prng_pkg::OP_RANGED, '0, 32'h7FFF_FFFF, 32'h8000_0000);
      // spans at and just above half the word, heavy rejection
      queue_request(prng_pkg::OP_RANGED, '0, 32'd0, 32'h7FFF_FFFF);
      queue_request(prng_pkg::OP_RANGED, '0, 32'h8000_0000, 32'd0);
      queue_request(prng_pkg::OP_RANGED, '0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      // unused opcode leaves the state alone
      queue_request(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(prng_pkg::OP_RAW,    '0, '0, '0);
      queue_request(prng_pkg::OP_RESEED, {$urandom, $urandom}, '0, '0);
      queue_request(prng_pkg::OP_RANGED, '0, -32'sd5, 32'd5);
      queue_request(prng_pkg::OP_RANGED, '0, -32'sd5, 32'd5);

      drawn = 0;
      while (drawn < RANDOM_DRAWS) begin
         pick        = $urandom_range(99);
         item.seed   = {$urandom, $urandom};
         item.lo     = $urandom;
         item.hi     = $urandom;
         if (pick < 8) begin
            item.opcode = prng_pkg::OP_RESEED;
         end else if (pick < 12) begin
            item.opcode = OP_UNUSED;
         end else if (pick < 45) begin
            item.opcode = prng_pkg::OP_RAW;
         end else begin
            item.opcode = prng_pkg::OP_RANGED;
            case ($urandom_range(5))
               1: item.hi = item.lo + $urandom_range(15);
               2: item.hi = item.lo + $urandom_range(32'h8000_FFFF, 32'h7FFF_FFFF);
               3: begin
                  item.lo = 32'h8000_0000;
                  item.hi = 32'h7FFF_FFFF;
               end
               4: item.hi = item.lo;
               5: item.hi = item.lo + $urandom_range(32'h0010_0000);
               default: ;
            endcase
         end
         queue_request(item.opcode, item.seed, item.lo, item.hi);
         if (item.opcode != OP_UNUSED)
            drawn++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_chan.valid || expected_values.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_values.size() == 0) begin
         $display("prng_with_bounded_range_draw regression: pass");
      end else begin
         $display("prng_with_bounded_range_draw regression: fail");
      end
      $finish;
   end

endmodule
